>>> rtl/lfu_pkg.sv
// Shared types and constants for the LFU page replacement block.
// No dependencies; imported by every module under rtl.
package lfu_pkg;

    // Number of frames in the resident table.
    localparam int FRAME_SLOTS = 8;
    // Bits to index one frame, and bits to count frames from 0 to FRAME_SLOTS.
    localparam int FRAME_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int FILL_W  = $clog2(FRAME_SLOTS + 1);

    // Item field widths.
    localparam int PAGE_W      = 16;
    localparam int COUNT_W     = 16;
    localparam int FAULT_W     = 32;
    localparam int CFG_W       = 4;
    localparam int FRAME_OUT_W = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    // Reset value of the frame limit register.
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(3);

    // Saturation limits.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic scan_step;
        logic commit;
    } lfu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } lfu_status_t;

endpackage

>>> rtl/lfu_ctrl.sv
// Controller state machine of the LFU page replacement block.
// Depends on lfu_pkg; drives lfu_dpath through lfu_cmd_t commands.
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  lfu_status_t status,
    output lfu_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // The walk examines one frame per cycle until a match or the fill count.
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                // Update the table once the output register can take the result.
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/lfu_dpath.sv
// Datapath of the LFU page replacement block: frame table, counters and result register.
// Depends on lfu_pkg; sequenced by lfu_ctrl.
module lfu_dpath
    import lfu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lfu_cmd_t               cmd,
    output lfu_status_t            status,
    input  logic [PAGE_W-1:0]      page_number,
    input  logic                   final_access,
    input  logic                   cfg_valid,
    input  logic [CFG_W-1:0]       cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   was_hit,
    output logic [FRAME_OUT_W-1:0] frame_used,
    output logic                   did_evict,
    output logic [PAGE_W-1:0]      evicted_page,
    output logic [FAULT_W-1:0]     fault_total
);

    // Frame table.
    logic [PAGE_W-1:0]  page_mem_reg [FRAME_SLOTS];
    logic [COUNT_W-1:0] cnt_mem_reg  [FRAME_SLOTS];

    // Control state.
    logic [CFG_W-1:0]   cfg_reg;
    logic [FILL_W-1:0]  filled_reg;
    logic [FAULT_W-1:0] fault_reg;
    logic [FILL_W-1:0]  idx_reg;
    logic               hit_reg;
    logic               out_valid_reg;

    // Per-item payload.
    logic [PAGE_W-1:0]  page_in_reg;
    logic               last_reg;
    logic [FRAME_W-1:0] hit_idx_reg;
    logic [COUNT_W-1:0] hit_cnt_reg;
    logic [FRAME_W-1:0] best_idx_reg;
    logic [COUNT_W-1:0] best_cnt_reg;
    logic [PAGE_W-1:0]  best_page_reg;

    // Result register.
    logic                   was_hit_reg;
    logic [FRAME_OUT_W-1:0] frame_used_reg;
    logic                   did_evict_reg;
    logic [PAGE_W-1:0]      evicted_page_reg;
    logic [FAULT_W-1:0]     fault_total_reg;

    logic [FRAME_W-1:0] scan_idx;
    logic               in_range;
    logic               match;
    logic               better;
    logic [FILL_W-1:0]  limit;
    logic               room;
    logic [FRAME_W-1:0] frame_next;
    logic               evict_next;
    logic [PAGE_W-1:0]  victim_next;
    logic [FAULT_W-1:0] fault_total_next;
    logic [COUNT_W-1:0] cnt_next;
    logic [FILL_W-1:0]  filled_next;

    // One frame is examined per scan step.
    assign scan_idx = idx_reg[FRAME_W-1:0];
    assign in_range = (idx_reg < filled_reg);
    assign match    = in_range && (page_mem_reg[scan_idx] == page_in_reg);
    assign better   = (idx_reg == '0) || (cnt_mem_reg[scan_idx] < best_cnt_reg);

    assign status.scan_done = !in_range || match;
    assign status.out_free  = !out_valid_reg || out_ready;

    // Frame limit: zero acts as one, values above the table size clamp to it.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            limit = FILL_W'(1);
        end
        else if (32'(cfg_reg) > 32'(FRAME_SLOTS))
        begin
            limit = FILL_W'(FRAME_SLOTS);
        end
        else
        begin
            limit = FILL_W'(cfg_reg);
        end
    end

    // Outcome of the item once the walk is over.
    always_comb
    begin
        room             = (filled_reg < limit);
        evict_next       = !hit_reg && !room;
        victim_next      = evict_next ? best_page_reg : '0;
        fault_total_next = fault_reg;
        cnt_next         = COUNT_W'(1);
        filled_next      = filled_reg;
        if (hit_reg)
        begin
            frame_next = hit_idx_reg;
            cnt_next   = (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg : hit_cnt_reg + 1'b1;
        end
        else
        begin
            if (fault_reg != FAULT_MAX)
            begin
                fault_total_next = fault_reg + 1'b1;
            end
            if (room)
            begin
                frame_next  = filled_reg[FRAME_W-1:0];
                filled_next = filled_reg + 1'b1;
            end
            else
            begin
                frame_next = best_idx_reg;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            filled_reg    <= '0;
            fault_reg     <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.start)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            else if (cmd.scan_step && in_range)
            begin
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.commit)
            begin
                filled_reg    <= last_reg ? '0 : filled_next;
                fault_reg     <= last_reg ? '0 : fault_total_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and frame table.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            page_in_reg <= page_number;
            last_reg    <= final_access;
        end
        if (cmd.scan_step && in_range)
        begin
            if (match)
            begin
                hit_idx_reg <= scan_idx;
                hit_cnt_reg <= cnt_mem_reg[scan_idx];
            end
            else if (better)
            begin
                best_idx_reg  <= scan_idx;
                best_cnt_reg  <= cnt_mem_reg[scan_idx];
                best_page_reg <= page_mem_reg[scan_idx];
            end
        end
        if (cmd.commit)
        begin
            page_mem_reg[frame_next] <= page_in_reg;
            cnt_mem_reg[frame_next]  <= cnt_next;
            was_hit_reg              <= hit_reg;
            frame_used_reg           <= FRAME_OUT_W'(frame_next);
            did_evict_reg            <= evict_next;
            evicted_page_reg         <= victim_next;
            fault_total_reg          <= fault_total_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign was_hit      = was_hit_reg;
    assign frame_used   = frame_used_reg;
    assign did_evict    = did_evict_reg;
    assign evicted_page = evicted_page_reg;
    assign fault_total  = fault_total_reg;

endmodule

>>> rtl/lfu_page_replacement.sv
// LFU page replacement block, top level. An accepted item first walks the frame table, one
// walk step per frame examined plus one past the last filled frame on a miss, and then
// commits its outcome into the result register.
// The next item is accepted in the idle state entered after the commit, so a new item is
// taken only once the last is through; a waiting result holds back only the commit of the item after it.
// Reset (rst_n, asynchronous, active low) empties the table and clears the fault count.
module lfu_page_replacement
    import lfu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] page_number
    input  logic                   s_axis_tlast,   // final_access
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] frame_used, [3] did_evict,
                                                   // [19:4] evicted_page, [51:20] fault_total
    output logic                   m_axis_tuser,   // was_hit
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data        // frames_in_use
);

    lfu_cmd_t               cmd;
    lfu_status_t            status;
    logic                   was_hit;
    logic [FRAME_OUT_W-1:0] frame_used;
    logic                   did_evict;
    logic [PAGE_W-1:0]      evicted_page;
    logic [FAULT_W-1:0]     fault_total;

    // The configuration register is always writable.
    assign cfg_ready = 1'b1;

    // Controller.
    lfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    lfu_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .page_number  (s_axis_tdata[PAGE_W-1:0]),
        .final_access (s_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .was_hit      (was_hit),
        .frame_used   (frame_used),
        .did_evict    (did_evict),
        .evicted_page (evicted_page),
        .fault_total  (fault_total)
    );

    // Pack the result item.
    assign m_axis_tuser = was_hit;
    assign m_axis_tdata = {4'b0000, fault_total, evicted_page, did_evict, frame_used};

endmodule
